// ----- hdl/battery_runtime_estimator_defines.svh -----
// Assertion macros of the battery runtime estimator RTL, used by the datapath.
`ifndef BATTERY_RUNTIME_ESTIMATOR_DEFINES_SVH
`define BATTERY_RUNTIME_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BRT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brt assertion failed");

// Next-cycle implication.
`define BRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brt assertion failed");

`endif

// ----- hdl/brt_pkg.sv -----
// Types and constants of the battery runtime estimator.
`timescale 1ns / 1ps
package brt_pkg;

   localparam int unsigned MvW       = 16;
   localparam int unsigned DropW     = 8;
   localparam int unsigned ChargeW   = 10;
   localparam int unsigned DaysW     = 8;
   localparam int unsigned HoursW    = 5;
   localparam int unsigned MinutesW  = 6;
   localparam int unsigned CsrIdxW   = 2;
   localparam int unsigned CsrDataW  = 16;
   localparam int unsigned DivNumW   = 32;
   localparam int unsigned DivDenW   = 16;
   localparam int unsigned SumW      = 32;
   localparam int unsigned CountW    = 16;

   // estimate split: total minutes up to 29 bits, total/60 and total/1440
   localparam int unsigned EstW      = 29;
   localparam int unsigned Q60W      = 23;
   localparam int unsigned Q24W      = 19;

   // reciprocals: x/15 for x < 2^27 and x/3 for x < 2^20, both exact
   localparam int unsigned             Recip15W  = 28;
   localparam logic [Recip15W-1:0]     Recip15   = 28'd143165577;
   localparam int unsigned             Recip15Sh = 31;
   localparam int unsigned             Recip3W   = 21;
   localparam logic [Recip3W-1:0]      Recip3    = 21'd1398102;
   localparam int unsigned             Recip3Sh  = 22;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrEmptyMv  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrFullMv   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrMinDrop  = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrLookback = 2'd3;

   // reset values
   localparam logic [MvW-1:0]   EmptyMvReset  = 16'd10800;
   localparam logic [MvW-1:0]   FullMvReset   = 16'd14500;
   localparam logic [DropW-1:0] MinDropReset  = 8'd4;
   localparam logic [DropW-1:0] LookbackReset = 8'd15;

   localparam logic [ChargeW-1:0] ChargeFull   = 10'd1000;
   localparam logic [9:0]         ChargeScale  = 10'd1000;
   localparam logic [DaysW-1:0]   DaysMax      = 8'd255;
   localparam logic [DivDenW-1:0] MinPerHour   = 16'd60;
   localparam logic [DivDenW-1:0] HourPerDay   = 16'd24;
   localparam logic [CountW-1:0]  CountMax     = 16'hFFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHG,
      S_CHG_W,
      S_MEAN,
      S_MEAN_W,
      S_PREP,
      S_SRD,
      S_SCHK,
      S_SLOPE,
      S_FALL,
      S_EST_W,
      S_HOUR,
      S_HOUR_W,
      S_DAY,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      DIV_CHARGE,
      DIV_MEAN,
      DIV_SLOPE,
      DIV_FALL
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        search_init;
      logic        search_read;
      logic        search_next;
      logic        hour_quot;
      logic        min_calc;
      logic        day_calc;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic close;
      logic below;
      logic i_ge_fill;
      logic match;
      logic rsp_busy;
   } status_type;

endpackage

// ----- hdl/brt_req_if.sv -----
// Input item channel: one voltage sample and its minute flag.
`timescale 1ns / 1ps
interface brt_req_if;
   logic                       valid;
   logic                       ready;
   logic [brt_pkg::MvW-1:0]    sample_mv;
   logic                       minute_end;

   modport source (output valid, output sample_mv, output minute_end, input ready);
   modport sink (input valid, input sample_mv, input minute_end, output ready);
endinterface

// ----- hdl/brt_rsp_if.sv -----
// Result item channel: charge and remaining runtime.
`timescale 1ns / 1ps
interface brt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [brt_pkg::ChargeW-1:0]     charge_permille;
   logic [brt_pkg::DaysW-1:0]       remain_days;
   logic [brt_pkg::HoursW-1:0]      remain_hours;
   logic [brt_pkg::MinutesW-1:0]    remain_minutes;

   modport source (output valid, output charge_permille, output remain_days,
                   output remain_hours, output remain_minutes, input ready);
   modport sink (input valid, input charge_permille, input remain_days,
                 input remain_hours, input remain_minutes, output ready);
endinterface

// ----- hdl/brt_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module brt_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [brt_pkg::DivNumW-1:0]  num,
   input  logic [brt_pkg::DivDenW-1:0]  den,
   output logic                         busy,
   output logic                         done,
   output logic [brt_pkg::DivNumW-1:0]  quo,
   output logic [brt_pkg::DivDenW-1:0]  rem
);
   import brt_pkg::*;

   localparam int unsigned CntW = $clog2(DivNumW);

   logic                busy_ff, done_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [DivNumW-1:0]  q_ff, q_in;
   logic [DivDenW-1:0]  r_ff, r_in, d_ff;
   logic [DivDenW:0]    trial, diff;
   logic                ge;

   // one shift-subtract step
   always_comb begin
      trial = {r_ff, q_ff[DivNumW-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = (trial >= {1'b0, d_ff});
      r_in  = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      q_in  = {q_ff[DivNumW-2:0], ge};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == {CntW{1'b1}}) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule

// ----- hdl/brt_dpath.sv -----
// Datapath: config registers, accumulator, history memory, estimate and result register.
`timescale 1ns / 1ps
`include "battery_runtime_estimator_defines.svh"
module brt_dpath #(
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [brt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [brt_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic [brt_pkg::MvW-1:0]       in_sample_mv,
   input  logic                          in_minute_end,
   input  brt_pkg::cmd_type              cmd,
   output brt_pkg::status_type           status,
   brt_rsp_if.source                     rsp
);
   import brt_pkg::*;

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned IW = (FW > DropW) ? FW : DropW;
   localparam int unsigned PW = IW + 2;
   localparam int unsigned TW = MvW + IW;
   localparam int unsigned P60W = EstW - 2 + Recip15W;
   localparam int unsigned P24W = Q60W - 3 + Recip3W;

   // configuration
   logic [MvW-1:0]   empty_ff, full_ff;
   logic [DropW-1:0] min_drop_ff, lookback_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff    <= EmptyMvReset;
         full_ff     <= FullMvReset;
         min_drop_ff <= MinDropReset;
         lookback_ff <= LookbackReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrEmptyMv:  empty_ff    <= csr_wdata;
            CsrFullMv:   full_ff     <= csr_wdata;
            CsrMinDrop:  min_drop_ff <= csr_wdata[DropW-1:0];
            CsrLookback: lookback_ff <= csr_wdata[DropW-1:0];
            default: ;
         endcase
      end
   end

   // state registers
   logic [MvW-1:0]      mv_ff;
   logic                close_ff;
   logic [SumW-1:0]     sum_ff;
   logic [CountW-1:0]   count_ff;
   logic [MvW-1:0]      mean_ff;
   logic [AW-1:0]       wptr_ff;
   logic [FW-1:0]       fill_ff;
   logic [IW-1:0]       i_ff, factor_ff;
   logic [MvW-1:0]      rd_ff;
   logic [TW-1:0]       total_ff;
   logic [Q60W-1:0]     hour_q_ff;
   logic [Q24W-1:0]     day_q_ff;
   logic [ChargeW-1:0]  charge_ff;
   logic [DaysW-1:0]    est_days_ff;
   logic [HoursW-1:0]   est_hours_ff;
   logic [MinutesW-1:0] est_min_ff;
   div_sel_type         op_ff;
   logic                rsp_valid_ff;
   logic [ChargeW-1:0]  rsp_charge_ff;
   logic [DaysW-1:0]    rsp_days_ff;
   logic [HoursW-1:0]   rsp_hours_ff;
   logic [MinutesW-1:0] rsp_min_ff;
   logic [MvW-1:0]      mem [HISTORY_DEPTH];

   // divider
   logic               div_busy, div_done;
   logic [DivNumW-1:0] div_num, div_quo;
   logic [DivDenW-1:0] div_den, div_rem;

   brt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // comparisons and derived values
   logic                mv_below, mv_full, mean_below, match;
   logic [MvW:0]        drop;
   logic [MvW-1:0]      rem_mv;
   logic [DropW-1:0]    fall_den;
   logic [25:0]         charge_num;
   logic [PW-1:0]       idx_sum, idx_wrap;
   logic [AW-1:0]       rd_idx;
   logic [TW-1:0]       total_in;
   logic [EstW-1:0]     est_num;
   logic [P60W-1:0]     q60_prod;
   logic [P24W-1:0]     q24_prod;

   always_comb begin
      mv_below   = (mv_ff < empty_ff);
      mv_full    = (mv_ff >= full_ff);
      mean_below = (mean_ff < empty_ff);
      rem_mv     = mean_below ? '0 : (mean_ff - empty_ff);
      drop       = {1'b0, rd_ff} - {1'b0, mean_ff};
      match      = (rd_ff > mean_ff) && (drop >= {{(MvW+1-DropW){1'b0}}, min_drop_ff});
      fall_den   = (min_drop_ff == '0) ? DropW'(1) : min_drop_ff;
      charge_num = (mv_ff - empty_ff) * ChargeScale;
      idx_sum    = PW'(wptr_ff) + PW'(HISTORY_DEPTH - 1) - PW'(i_ff);
      idx_wrap   = (idx_sum >= PW'(HISTORY_DEPTH)) ? idx_sum - PW'(HISTORY_DEPTH) : idx_sum;
      rd_idx     = idx_wrap[AW-1:0];
      total_in   = TW'(div_quo[MvW-1:0]) * TW'(factor_ff);
      // total/60 as (total/4)/15, then (total/60)/24 as ((total/60)/8)/3
      est_num    = EstW'(total_ff);
      q60_prod   = P60W'(est_num[EstW-1:2]) * P60W'(Recip15);
      q24_prod   = P24W'(hour_q_ff[Q60W-1:3]) * P24W'(Recip3);
   end

   // divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         DIV_CHARGE: begin
            div_num = DivNumW'(charge_num);
            div_den = full_ff - empty_ff;
         end
         DIV_MEAN: begin
            div_num = sum_ff;
            div_den = count_ff;
         end
         DIV_SLOPE: begin
            div_num = DivNumW'(rem_mv);
            div_den = drop[MvW-1:0];
         end
         DIV_FALL: begin
            div_num = DivNumW'(rem_mv);
            div_den = DivDenW'(fall_den);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   // control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         est_days_ff  <= '0;
         est_hours_ff <= '0;
         est_min_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= DIV_CHARGE;
      end else begin
         // accumulate the accepted sample
         if (cmd.accept && (count_ff < CountMax)) begin
            sum_ff   <= sum_ff + SumW'(in_sample_mv);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.div_start) begin
            op_ff <= cmd.div_sel;
         end
         // close of a minute: clear sum and count, advance ring pointer and fill
         if (div_done && (op_ff == DIV_MEAN)) begin
            sum_ff   <= '0;
            count_ff <= '0;
            wptr_ff  <= (wptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
            if (fill_ff < FW'(HISTORY_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         // minutes within the hour
         if (cmd.min_calc) begin
            est_min_ff <= MinutesW'(est_num - EstW'(hour_q_ff) * EstW'(MinPerHour));
         end
         // hours within the day and saturated days
         if (cmd.day_calc) begin
            est_hours_ff <= HoursW'(hour_q_ff - Q60W'(day_q_ff) * Q60W'(HourPerDay));
            est_days_ff  <= (day_q_ff > Q24W'(DaysMax)) ? DaysMax : day_q_ff[DaysW-1:0];
         end
         // result register
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mv_ff    <= in_sample_mv;
         close_ff <= in_minute_end;
      end
      if (div_done && (op_ff == DIV_CHARGE)) begin
         charge_ff <= mv_below ? '0 : (mv_full ? ChargeFull : div_quo[ChargeW-1:0]);
      end
      if (div_done && (op_ff == DIV_MEAN)) begin
         mean_ff <= div_quo[MvW-1:0];
      end
      if (cmd.search_init) begin
         i_ff <= IW'(lookback_ff);
      end else if (cmd.search_next) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.div_start && (cmd.div_sel == DIV_SLOPE)) begin
         factor_ff <= i_ff;
      end else if (cmd.div_start && (cmd.div_sel == DIV_FALL)) begin
         factor_ff <= IW'(fill_ff);
      end
      if (div_done && ((op_ff == DIV_SLOPE) || (op_ff == DIV_FALL))) begin
         total_ff <= total_in;
      end
      if (cmd.hour_quot) begin
         hour_q_ff <= q60_prod[Recip15Sh +: Q60W];
      end
      if (cmd.min_calc) begin
         day_q_ff <= q24_prod[Recip3Sh +: Q24W];
      end
      if (cmd.rsp_load) begin
         rsp_charge_ff <= charge_ff;
         rsp_days_ff   <= est_days_ff;
         rsp_hours_ff  <= est_hours_ff;
         rsp_min_ff    <= est_min_ff;
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (div_done && (op_ff == DIV_MEAN)) begin
         mem[wptr_ff] <= div_quo[MvW-1:0];
      end
      if (cmd.search_read) begin
         rd_ff <= mem[rd_idx];
      end
   end

   always_comb begin
      status.div_done  = div_done;
      status.close     = close_ff;
      status.below     = mean_below;
      status.i_ge_fill = (i_ff >= IW'(fill_ff));
      status.match     = match;
      status.rsp_busy  = rsp_valid_ff && !rsp.ready;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.charge_permille = rsp_charge_ff;
   assign rsp.remain_days     = rsp_days_ff;
   assign rsp.remain_hours    = rsp_hours_ff;
   assign rsp.remain_minutes  = rsp_min_ff;

   `BRT_ASSERT_IMPL(a_div_idle_start, cmd.div_start, !div_busy)
   `BRT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FW'(HISTORY_DEPTH))
   `BRT_ASSERT_IMPL(a_hours_range, 1'b1, est_hours_ff < HoursW'(HourPerDay))
   `BRT_ASSERT_IMPL(a_min_range, 1'b1, est_min_ff < MinutesW'(MinPerHour))
   `BRT_ASSERT_NEXT(a_load_holds, cmd.rsp_load, rsp_valid_ff)
endmodule

// ----- hdl/brt_ctrl.sv -----
// Controller: sequences one item through charge, minute close, search and estimate.
`timescale 1ns / 1ps
module brt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  brt_pkg::status_type   status,
   output brt_pkg::cmd_type      cmd
);
   import brt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (in_valid) state_in = S_CHG;
         S_CHG:    state_in = S_CHG_W;
         S_CHG_W:  if (status.div_done) state_in = status.close ? S_MEAN : S_OUT;
         S_MEAN:   state_in = S_MEAN_W;
         S_MEAN_W: if (status.div_done) state_in = S_PREP;
         S_PREP:   state_in = status.below ? S_FALL : S_SRD;
         S_SRD:    state_in = status.i_ge_fill ? S_FALL : S_SCHK;
         S_SCHK:   state_in = status.match ? S_SLOPE : S_SRD;
         S_SLOPE:  state_in = S_EST_W;
         S_FALL:   state_in = S_EST_W;
         S_EST_W:  if (status.div_done) state_in = S_HOUR;
         S_HOUR:   state_in = S_HOUR_W;
         S_HOUR_W: state_in = S_DAY;
         S_DAY:    state_in = S_OUT;
         S_OUT:    if (!status.rsp_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.div_sel  = DIV_CHARGE;
      in_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready   = 1'b1;
            cmd.accept = in_valid;
         end
         S_CHG: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CHARGE;
         end
         S_MEAN: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
         end
         S_PREP:  cmd.search_init = !status.below;
         S_SRD:   cmd.search_read = !status.i_ge_fill;
         S_SCHK:  cmd.search_next = !status.match;
         S_SLOPE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SLOPE;
         end
         S_FALL: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FALL;
         end
         S_HOUR:   cmd.hour_quot = 1'b1;
         S_HOUR_W: cmd.min_calc  = 1'b1;
         S_DAY:    cmd.day_calc  = 1'b1;
         S_OUT:    cmd.rsp_load  = !status.rsp_busy;
         default: ;
      endcase
   end
endmodule

// ----- hdl/battery_runtime_estimator.sv -----
// Top level of the battery runtime estimator.
`timescale 1ns / 1ps
// Usage:
//  req carries one voltage sample (sample_mv) and minute_end; rsp returns the
//  sample's charge in permille and the held runtime estimate in days, hours
//  and minutes. csr_we/csr_index/csr_wdata write empty_mv, full_mv,
//  min_drop_mv and lookback_start (index 0..3); the user must write them
//  only while the block is idle; the block itself does not enforce this.
//  One item is worked at a time on a shared 32-step restoring divider.
//  A plain sample goes through the charge division and is then loaded into
//  the result register; the next item is accepted only after that load.
//  A minute-closing sample adds the mean division, a history walk (read
//  port, then compare, for each examined entry), the slope division (the fall
//  division when no entry matches or the mean is below empty) and the
//  reciprocal multiplies for hours and days in S_HOUR, S_HOUR_W and S_DAY.
//  Reset restores the register defaults and clears sum, count, ring pointer,
//  fill and estimate; history memory is not cleared, only filled entries are
//  read. The result waits in an output register; while rsp is stalled the
//  next item is still accepted and worked, and its result is loaded once the
//  register is taken.
module battery_runtime_estimator #(
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   brt_req_if.sink                       req,
   brt_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [brt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [brt_pkg::CsrDataW-1:0]  csr_wdata
);
   import brt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;

   brt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (ready),
      .status   (status),
      .cmd      (cmd)
   );

   brt_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_sample_mv  (req.sample_mv),
      .in_minute_end (req.minute_end),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp)
   );

   assign req.ready = ready;
endmodule

// ----- sim/battery_runtime_estimator_test.sv -----
// Self-checking testbench for the battery runtime estimator.
`timescale 1ns / 1ps
module battery_runtime_estimator_test;
   import brt_pkg::*;

   localparam int unsigned RingDepth = 256;

   typedef struct packed {
      logic [ChargeW-1:0]  charge;
      logic [DaysW-1:0]    days;
      logic [HoursW-1:0]   hours;
      logic [MinutesW-1:0] mins;
   } reading_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [CsrIdxW-1:0]  idx;
      logic [MvW-1:0]      val;
      logic                close;
      bit                  typed;
      reading_type         want;
   } row_type;

   logic clock;
   logic reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   brt_req_if req ();
   brt_rsp_if rsp ();

   battery_runtime_estimator u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [MvW-1:0]   cfg_empty, cfg_full;
   logic [DropW-1:0] cfg_drop, cfg_lookback;
   int unsigned      acc_sum, acc_count, ring_fill;
   logic [7:0]       wr_ptr;
   logic [15:0]      ring [RingDepth];
   reading_type      held;

   reading_type readings_due [$];
   int unsigned errors;
   bit          calm;
   logic [MvW-1:0] cur_mv;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input reading_type got, input reading_type want);
      errors++;
      $display("mismatch %s: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d", what,
               got.charge, got.days, got.hours, got.mins,
               want.charge, want.days, want.hours, want.mins);
   endtask

   function automatic logic [15:0] ring_age(int unsigned age);
      logic [7:0] slot;
      slot = wr_ptr - 8'd1 - age[7:0];
      return ring[slot];
   endfunction

   // charge of one sample plus the held runtime estimate after it
   function automatic reading_type gauge_step(logic [MvW-1:0] mv, logic close);
      int unsigned mean, now, older, rem, total, div, i, days;
      bit hit;
      reading_type r;
      if (acc_count < 32'hFFFF) begin
         acc_sum += mv;
         acc_count++;
      end
      if (close) begin
         mean = acc_sum / acc_count;
         ring[wr_ptr] = mean[15:0];
         wr_ptr++;
         if (ring_fill < RingDepth) ring_fill++;
         acc_sum = 0;
         acc_count = 0;
         now = ring_age(0);
         total = 0;
         if (now >= cfg_empty) begin
            rem = now - cfg_empty;
            hit = 0;
            for (i = cfg_lookback; i < ring_fill && !hit; i++) begin
               older = ring_age(i);
               if (older > now && older - now >= cfg_drop) begin
                  total = (rem / (older - now)) * i;
                  hit = 1;
               end
            end
            if (!hit) begin
               div = (cfg_drop == 0) ? 1 : cfg_drop;
               total = (rem / div) * ring_fill;
            end
         end
         days = total / 1440;
         held.days  = (days > 255) ? DaysMax : days[7:0];
         held.hours = HoursW'((total / 60) % 24);
         held.mins  = MinutesW'(total % 60);
      end
      r = held;
      if (mv < cfg_empty) r.charge = '0;
      else if (mv >= cfg_full) r.charge = ChargeFull;
      else r.charge = ChargeW'(((32'(mv) - cfg_empty) * 1000) / (32'(cfg_full) - cfg_empty));
      return r;
   endfunction

   task automatic drain();
      while (readings_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [MvW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrEmptyMv:  cfg_empty    = val;
         CsrFullMv:   cfg_full     = val;
         CsrMinDrop:  cfg_drop     = val[7:0];
         CsrLookback: cfg_lookback = val[7:0];
      endcase
   endtask

   // one sample item; expectation is queued at its acceptance edge
   task automatic send(input logic [MvW-1:0] mv, input logic close, input bit typed,
                       input reading_type want);
      reading_type p;
      if (!calm && $urandom_range(99) < 17) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.sample_mv  <= mv;
      req.minute_end <= close;
      do @(posedge clock); while (!req.ready);
      p = gauge_step(mv, close);
      readings_due.push_back(typed ? want : p);
   endtask

   // random minute: a few samples near the current level, last one closes it
   task automatic send_minute(output int unsigned sent);
      int unsigned k;
      logic [MvW-1:0] mv;
      sent = $urandom_range(1, 4);
      for (k = 0; k < sent; k++) begin
         mv = 16'(cur_mv + $urandom_range(0, 4) - 2);
         send(mv, k == sent - 1, 0, '0);
      end
      if (cur_mv < cfg_empty + 50 || cur_mv < 100) cur_mv = 16'(cfg_full + $urandom_range(0, 200));
      else cur_mv = 16'(cur_mv - $urandom_range(0, 6));
   endtask

   // result checking
   always @(posedge clock) begin
      reading_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.charge_permille, rsp.remain_days, rsp.remain_hours, rsp.remain_minutes};
         if (readings_due.size() == 0) begin
            report("unexpected item", got, '0);
         end else begin
            want = readings_due.pop_front();
            if (got.charge !== want.charge) report("charge", got, want);
            if (got.days !== want.days) report("days", got, want);
            if (got.hours !== want.hours) report("hours", got, want);
            if (got.mins !== want.mins) report("minutes", got, want);
         end
      end
   end

   // result-side stalls
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      row_type rows [$];
      row_type r;
      int unsigned p, n, k;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req.valid  = 1'b0;
      req.sample_mv  = '0;
      req.minute_end = 1'b0;
      errors = 0;
      calm = 0;
      cfg_empty = EmptyMvReset;
      cfg_full = FullMvReset;
      cfg_drop = MinDropReset;
      cfg_lookback = LookbackReset;
      acc_sum = 0;
      acc_count = 0;
      ring_fill = 0;
      wr_ptr = '0;
      held = '0;

      // directed rows: extremes, each register and the corner cases
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd0,     1'b0, 1, '{10'd0, 0, 0, 0}});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd65535, 1'b0, 1, '{10'd1000, 0, 0, 0}});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd10800, 1'b0, 1, '{10'd0, 0, 0, 0}});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd14499, 1'b0, 1, '{10'd999, 0, 0, 0}});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd12000, 1'b1, 0, '0});
      // minute mean below empty clears the estimate
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd5000,  1'b1, 1, '{10'd0, 0, 0, 0}});
      rows.push_back('{ROW_CSR,    CsrMinDrop, 16'd0,     1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrLookback, 16'd0,    1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd12000, 1'b1, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd11990, 1'b1, 0, '0});
      rows.push_back('{ROW_CSR,    CsrLookback, 16'd255,  1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrMinDrop, 16'd255,   1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd11000, 1'b1, 0, '0});
      rows.push_back('{ROW_CSR,    CsrEmptyMv, 16'd0,     1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrFullMv,  16'd65535, 1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd65535, 1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd32768, 1'b1, 0, '0});
      // full not above empty
      rows.push_back('{ROW_CSR,    CsrFullMv,  16'd0,     1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd0,     1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrEmptyMv, 16'd65535, 1'b0, 0, '0});
      rows.push_back('{ROW_SAMPLE, CsrEmptyMv, 16'd65534, 1'b1, 0, '0});
      rows.push_back('{ROW_CSR,    CsrEmptyMv, EmptyMvReset, 1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrFullMv,  FullMvReset,  1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrMinDrop, 16'(MinDropReset),  1'b0, 0, '0});
      rows.push_back('{ROW_CSR,    CsrLookback, 16'(LookbackReset), 1'b0, 0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         if (r.kind == ROW_CSR) begin
            req.valid <= 1'b0;
            @(posedge clock);
            drain();
            csr_write(r.idx, r.val);
         end else begin
            send(r.val, r.close, r.typed, r.want);
         end
      end

      // random phases, each under its own register setting
      for (p = 0; p < 5; p++) begin
         req.valid <= 1'b0;
         @(posedge clock);
         drain();
         csr_write(CsrEmptyMv, 16'($urandom_range(9000, 12000)));
         csr_write(CsrFullMv, 16'(cfg_empty + $urandom_range(1, 5000)));
         csr_write(CsrMinDrop, (p == 4) ? 16'd1 : 16'($urandom_range(1, 12)));
         csr_write(CsrLookback, (p == 4) ? 16'd1 : 16'($urandom_range(1, 30)));
         cur_mv = cfg_full;
         calm = (p == 3);
         n = 0;
         while (n < 165) begin
            if (p == 2 && n >= 80 && n < 84) begin
               // hold off until every result is back
               req.valid <= 1'b0;
               @(posedge clock);
               while (readings_due.size() != 0) @(posedge clock);
               n = 84;
            end
            if ($urandom_range(99) < 85) begin
               send_minute(k);
               n += k;
            end else begin
               send(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 0, '0);
               n++;
            end
         end
      end
      calm = 0;
      req.valid <= 1'b0;

      while (readings_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- battery_runtime_estimator.f -----
+incdir+hdl
hdl/brt_pkg.sv
hdl/brt_req_if.sv
hdl/brt_rsp_if.sv
hdl/brt_div.sv
hdl/brt_dpath.sv
hdl/brt_ctrl.sv
hdl/battery_runtime_estimator.sv
sim/battery_runtime_estimator_test.sv
